>>> rtl/crcbec_pkg.sv
// Package for the CRC-32 bit error corrector.
// Holds the shared constants, codes, command and status structs, and CRC step functions.
// No dependencies.
package crcbec_pkg;

    localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
    localparam logic [31:0] PATTERN_START = 32'h8000_0000;

    // Register indexes, taken from paddr[2].
    localparam logic REG_PAGE_BYTES = 1'b0;
    localparam logic REG_TWO_BIT    = 1'b1;

    typedef enum logic [1:0] {
        RES_OK   = 2'd0,
        RES_ONE  = 2'd1,
        RES_TWO  = 2'd2,
        RES_FAIL = 2'd3
    } result_t;

    typedef enum logic [1:0] {
        ST_ACCEPT,
        ST_SINGLE,
        ST_PAIR
    } state_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_NEXT_OUTER,
        OP_RESTART,
        OP_NEXT_INNER,
        OP_WRAP_INNER
    } search_op_t;

    typedef struct packed {
        logic       fold;
        search_op_t op;
        logic       load;
        result_t    code;
    } cmd_t;

    typedef struct packed {
        logic final_next;
        logic syn_zero;
        logic single_hit;
        logic pair_hit;
        logic outer_last;
        logic inner_last;
    } stat_t;

    function automatic logic [31:0] lfsr_next(input logic [31:0] e);
        return (e >> 1) ^ (e[0] ? CRC_POLY : 32'h0000_0000);
    endfunction

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] d);
        logic [31:0] c;
        c = crc ^ {24'h00_0000, d};
        for (int i = 0; i < 8; i++) begin
            c = lfsr_next(c);
        end
        return c;
    endfunction

endpackage

>>> rtl/crc32_bit_error_corrector_core.sv
// Top level of the CRC-32 bit error corrector: configuration registers, controller, datapath.
// Depends on crcbec_pkg, crcbec_ctrl and crcbec_datapath.
//
//   Channel   Direction  Handshake         Carries
//   s_        in         s_valid/s_ready   one page byte; stored CRC with the final byte
//   m_        out        m_valid/m_ready   one result per page: status and flip positions
//   APB       in         psel/penable      page_bytes at 0x0, two_bit_enable at 0x4
//
// Page bytes are taken one per cycle. The final byte is taken only when the result
// register is free. After it, the search unit first checks for a clean page, then scans
// the L = (clamped page size + 4) * 8 codeword bits for a single-bit flip and, when
// two_bit_enable is set, every ordered pair of them, stepping the search LFSRs.
// No byte is taken during a search. Reset (aresetn low at a clock edge) returns the
// controller to byte intake with an empty result register and a fresh CRC.
module crc32_bit_error_corrector_core #(
    parameter int MAX_PAGE_BYTES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic [31:0] s_page_crc,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic        m_first_valid,
    output logic [7:0]  m_first_byte,
    output logic [2:0]  m_first_bit,
    output logic        m_second_valid,
    output logic [7:0]  m_second_byte,
    output logic [2:0]  m_second_bit
);

    logic [8:0]        page_bytes_reg;
    logic              two_bit_reg;
    logic              cfg_write;
    crcbec_pkg::cmd_t  cmd;
    crcbec_pkg::stat_t stat;

    // The register port never stalls; a write lands in the access phase.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_bytes_reg <= 9'd256;
            two_bit_reg    <= 1'b0;
        end else if (cfg_write) begin
            unique case (paddr[2])
                crcbec_pkg::REG_PAGE_BYTES: page_bytes_reg <= pwdata[8:0];
                crcbec_pkg::REG_TWO_BIT:    two_bit_reg    <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            crcbec_pkg::REG_PAGE_BYTES: prdata = {23'h00_0000, page_bytes_reg};
            crcbec_pkg::REG_TWO_BIT:    prdata = {31'h0000_0000, two_bit_reg};
            default:                    prdata = 32'h0000_0000;
        endcase
    end

    // The controller decides what happens each cycle; the datapath only reports
    // comparisons and counter ends back to it.
    crcbec_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .two_bit_enable (two_bit_reg),
        .stat           (stat),
        .cmd            (cmd)
    );

    crcbec_datapath #(
        .MAX_PAGE_BYTES (MAX_PAGE_BYTES)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .page_bytes   (page_bytes_reg),
        .data_byte    (s_data_byte),
        .page_crc     (s_page_crc),
        .status       (m_status),
        .first_valid  (m_first_valid),
        .first_byte   (m_first_byte),
        .first_bit    (m_first_bit),
        .second_valid (m_second_valid),
        .second_byte  (m_second_byte),
        .second_bit   (m_second_bit)
    );

`ifndef SYNTHESIS
    // A result must never be written over one that is still waiting.
    assert property (@(posedge aclk) disable iff (!aresetn) cmd.load |-> !m_valid)
        else $error("result loaded while the result register was full");

    // A clean page reports no flip positions.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == crcbec_pkg::RES_OK) |-> (!m_first_valid && !m_second_valid))
        else $error("clean page reported a flip position");

    // A single-bit correction never carries a second position.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == crcbec_pkg::RES_ONE) |-> !m_second_valid)
        else $error("single-bit correction reported a second position");

    // Taking the final byte of a page starts a search, so intake stops next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && stat.final_next) |=> !s_ready)
        else $error("byte intake continued after the final byte");
`endif

endmodule

>>> rtl/crcbec_ctrl.sv
// Controller state machine of the CRC-32 bit error corrector.
// Sequences byte intake, the single-bit and pairwise searches, and the result register.
// Depends on crcbec_pkg.
module crcbec_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  logic              two_bit_enable,
    input  crcbec_pkg::stat_t stat,
    output crcbec_pkg::cmd_t  cmd
);

    crcbec_pkg::state_t state_reg, state_next;
    logic               out_full_reg, out_full_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= crcbec_pkg::ST_ACCEPT;
            out_full_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            out_full_reg <= out_full_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd.fold   = 1'b0;
        cmd.op     = crcbec_pkg::OP_HOLD;
        cmd.load   = 1'b0;
        cmd.code   = crcbec_pkg::RES_OK;

        unique case (state_reg)
            crcbec_pkg::ST_ACCEPT: begin
                // The final byte waits until the result register is free.
                s_ready = !out_full_reg || !stat.final_next;
                if (s_valid && s_ready) begin
                    cmd.fold = 1'b1;
                    if (stat.final_next) begin
                        state_next = crcbec_pkg::ST_SINGLE;
                    end
                end
            end
            crcbec_pkg::ST_SINGLE: begin
                if (stat.syn_zero) begin
                    cmd.load   = 1'b1;
                    cmd.code   = crcbec_pkg::RES_OK;
                    state_next = crcbec_pkg::ST_ACCEPT;
                end else if (stat.single_hit) begin
                    cmd.load   = 1'b1;
                    cmd.code   = crcbec_pkg::RES_ONE;
                    state_next = crcbec_pkg::ST_ACCEPT;
                end else if (stat.outer_last) begin
                    if (two_bit_enable) begin
                        cmd.op     = crcbec_pkg::OP_RESTART;
                        state_next = crcbec_pkg::ST_PAIR;
                    end else begin
                        cmd.load   = 1'b1;
                        cmd.code   = crcbec_pkg::RES_FAIL;
                        state_next = crcbec_pkg::ST_ACCEPT;
                    end
                end else begin
                    cmd.op = crcbec_pkg::OP_NEXT_OUTER;
                end
            end
            crcbec_pkg::ST_PAIR: begin
                if (stat.pair_hit) begin
                    cmd.load   = 1'b1;
                    cmd.code   = crcbec_pkg::RES_TWO;
                    state_next = crcbec_pkg::ST_ACCEPT;
                end else if (stat.inner_last) begin
                    if (stat.outer_last) begin
                        cmd.load   = 1'b1;
                        cmd.code   = crcbec_pkg::RES_FAIL;
                        state_next = crcbec_pkg::ST_ACCEPT;
                    end else begin
                        cmd.op = crcbec_pkg::OP_WRAP_INNER;
                    end
                end else begin
                    cmd.op = crcbec_pkg::OP_NEXT_INNER;
                end
            end
            default: begin
                state_next = crcbec_pkg::ST_ACCEPT;
            end
        endcase

        out_full_next = cmd.load || (out_full_reg && !m_ready);
    end

    assign m_valid = out_full_reg;

endmodule

>>> rtl/crcbec_datapath.sv
// Datapath of the CRC-32 bit error corrector.
// Holds the CRC accumulator, byte counter, syndrome, search LFSRs and the result register.
// Depends on crcbec_pkg.
module crcbec_datapath #(
    parameter int MAX_PAGE_BYTES = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  crcbec_pkg::cmd_t  cmd,
    output crcbec_pkg::stat_t stat,
    input  logic [8:0]        page_bytes,
    input  logic [7:0]        data_byte,
    input  logic [31:0]       page_crc,
    output logic [1:0]        status,
    output logic              first_valid,
    output logic [7:0]        first_byte,
    output logic [2:0]        first_bit,
    output logic              second_valid,
    output logic [7:0]        second_byte,
    output logic [2:0]        second_bit
);

    localparam int SIZE_W = $clog2(MAX_PAGE_BYTES + 1);
    localparam int POS_W  = $clog2((MAX_PAGE_BYTES + 4) * 8);

    logic [31:0]       crc_reg, crc_next;
    logic [SIZE_W-1:0] count_reg, count_next;
    logic [31:0]       syndrome_reg, syndrome_next;
    logic [POS_W-1:0]  last_pos_reg, last_pos_next;
    logic [31:0]       outer_pat_reg, outer_pat_next;
    logic [31:0]       inner_pat_reg, inner_pat_next;
    logic [POS_W-1:0]  outer_idx_reg, outer_idx_next;
    logic [POS_W-1:0]  inner_idx_reg, inner_idx_next;

    logic [1:0]        status_reg;
    logic              first_valid_reg, second_valid_reg;
    logic [7:0]        first_byte_reg, second_byte_reg;
    logic [2:0]        first_bit_reg, second_bit_reg;

    logic [SIZE_W-1:0] eff_size;
    logic [SIZE_W:0]   count_inc;
    logic [31:0]       crc_folded;
    logic [POS_W-1:0]  first_pos, second_pos;
    logic [POS_W+7:0]  first_wide, second_wide;
    logic              first_in_data, second_in_data;

    // Page size clamped into 1..MAX_PAGE_BYTES.
    always_comb begin
        if (page_bytes == 9'd0) begin
            eff_size = SIZE_W'(1);
        end else if (32'(page_bytes) > 32'(MAX_PAGE_BYTES)) begin
            eff_size = SIZE_W'(MAX_PAGE_BYTES);
        end else begin
            eff_size = SIZE_W'(page_bytes);
        end
    end

    assign count_inc  = {1'b0, count_reg} + (SIZE_W + 1)'(1);
    assign crc_folded = crcbec_pkg::crc_byte(crc_reg, data_byte);

    assign stat.final_next = count_inc >= {1'b0, eff_size};
    assign stat.syn_zero   = syndrome_reg == 32'h0000_0000;
    assign stat.single_hit = outer_pat_reg == syndrome_reg;
    assign stat.pair_hit   = (outer_pat_reg ^ inner_pat_reg) == syndrome_reg;
    assign stat.outer_last = outer_idx_reg == last_pos_reg;
    assign stat.inner_last = inner_idx_reg == last_pos_reg;

    always_comb begin
        crc_next       = crc_reg;
        count_next     = count_reg;
        syndrome_next  = syndrome_reg;
        last_pos_next  = last_pos_reg;
        outer_pat_next = outer_pat_reg;
        outer_idx_next = outer_idx_reg;
        inner_pat_next = inner_pat_reg;
        inner_idx_next = inner_idx_reg;

        if (cmd.fold) begin
            if (stat.final_next) begin
                crc_next       = crcbec_pkg::CRC_INIT;
                count_next     = '0;
                syndrome_next  = ~crc_folded ^ page_crc;
                last_pos_next  = POS_W'(((32'(eff_size) + 32'd4) << 3) - 32'd1);
                outer_pat_next = crcbec_pkg::PATTERN_START;
                outer_idx_next = '0;
            end else begin
                crc_next   = crc_folded;
                count_next = count_inc[SIZE_W-1:0];
            end
        end

        case (cmd.op)
            crcbec_pkg::OP_NEXT_OUTER: begin
                outer_pat_next = crcbec_pkg::lfsr_next(outer_pat_reg);
                outer_idx_next = outer_idx_reg + POS_W'(1);
            end
            crcbec_pkg::OP_RESTART: begin
                outer_pat_next = crcbec_pkg::PATTERN_START;
                outer_idx_next = '0;
                inner_pat_next = crcbec_pkg::PATTERN_START;
                inner_idx_next = '0;
            end
            crcbec_pkg::OP_NEXT_INNER: begin
                inner_pat_next = crcbec_pkg::lfsr_next(inner_pat_reg);
                inner_idx_next = inner_idx_reg + POS_W'(1);
            end
            crcbec_pkg::OP_WRAP_INNER: begin
                outer_pat_next = crcbec_pkg::lfsr_next(outer_pat_reg);
                outer_idx_next = outer_idx_reg + POS_W'(1);
                inner_pat_next = crcbec_pkg::PATTERN_START;
                inner_idx_next = '0;
            end
            default: begin
            end
        endcase
    end

    // Search step i stands for codeword bit last_pos - i, counted LSB first.
    assign first_pos      = last_pos_reg - outer_idx_reg;
    assign second_pos     = last_pos_reg - inner_idx_reg;
    assign first_wide     = {8'h00, first_pos} >> 3;
    assign second_wide    = {8'h00, second_pos} >> 3;
    assign first_in_data  = 32'(first_wide) < 32'(eff_size);
    assign second_in_data = 32'(second_wide) < 32'(eff_size);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg   <= crcbec_pkg::CRC_INIT;
            count_reg <= '0;
        end else begin
            crc_reg   <= crc_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        syndrome_reg  <= syndrome_next;
        last_pos_reg  <= last_pos_next;
        outer_pat_reg <= outer_pat_next;
        outer_idx_reg <= outer_idx_next;
        inner_pat_reg <= inner_pat_next;
        inner_idx_reg <= inner_idx_next;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            status_reg       <= cmd.code;
            first_valid_reg  <= 1'b0;
            first_byte_reg   <= 8'h00;
            first_bit_reg    <= 3'd0;
            second_valid_reg <= 1'b0;
            second_byte_reg  <= 8'h00;
            second_bit_reg   <= 3'd0;
            case (cmd.code) inside
                crcbec_pkg::RES_ONE, crcbec_pkg::RES_TWO: begin
                    if (first_in_data) begin
                        first_valid_reg <= 1'b1;
                        first_byte_reg  <= first_wide[7:0];
                        first_bit_reg   <= first_pos[2:0];
                    end
                    if (cmd.code == crcbec_pkg::RES_TWO && second_in_data) begin
                        second_valid_reg <= 1'b1;
                        second_byte_reg  <= second_wide[7:0];
                        second_bit_reg   <= second_pos[2:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign status       = status_reg;
    assign first_valid  = first_valid_reg;
    assign first_byte   = first_byte_reg;
    assign first_bit    = first_bit_reg;
    assign second_valid = second_valid_reg;
    assign second_byte  = second_byte_reg;
    assign second_bit   = second_bit_reg;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for crc32_bit_error_corrector_core: page bytes in, fix reports out.
// Depends on crcbec_pkg for the result codes, register indexes and CRC constants.
module testbench;

    localparam int MAX_PAGE     = 256;
    localparam int MAX_STEPS    = (MAX_PAGE + 4) * 8;
    localparam int QUIET_LIMIT  = 60000;

    // Where one flip lands in the page, as the block reports it.
    typedef struct packed {
        logic       valid;
        logic [7:0] byte_idx;
        logic [2:0] bit_idx;
    } flip_loc_t;

    typedef struct packed {
        crcbec_pkg::result_t status;
        flip_loc_t           first;
        flip_loc_t           second;
    } fix_report_t;

    // One directed request: the config it runs under, the clean byte, the bits flipped on
    // the way in, the bits flipped in the stored CRC, and a hand-written status where the
    // answer is obvious (all other report fields are then zero).
    typedef struct packed {
        logic [8:0]          pg;
        logic                two;
        logic [7:0]          data;
        logic [7:0]          flip;
        logic [31:0]         crc_flip;
        logic                typed;
        crcbec_pkg::result_t want;
    } dir_row_t;

    typedef struct packed {
        logic [8:0] pg;
        logic       two;
        logic [7:0] pages;
        logic [6:0] gap_pct;
        logic [1:0] stall;
    } phase_t;

    localparam int N_DIRECTED = 18;
    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        // One-byte pages, single-bit search only.
        '{9'd1,   1'b0, 8'h00, 8'h00, 32'h0000_0000, 1'b1, crcbec_pkg::RES_OK},
        '{9'd1,   1'b0, 8'hFF, 8'h00, 32'h0000_0000, 1'b1, crcbec_pkg::RES_OK},
        '{9'd1,   1'b0, 8'hA5, 8'h00, 32'h8000_0000, 1'b1, crcbec_pkg::RES_ONE},
        '{9'd1,   1'b0, 8'h5A, 8'h00, 32'h0000_0001, 1'b1, crcbec_pkg::RES_ONE},
        '{9'd1,   1'b0, 8'h3C, 8'h01, 32'h0000_0000, 1'b0, crcbec_pkg::RES_OK},
        '{9'd1,   1'b0, 8'hC3, 8'h80, 32'h0000_0000, 1'b0, crcbec_pkg::RES_OK},
        '{9'd1,   1'b0, 8'h77, 8'h00, 32'h0000_0003, 1'b1, crcbec_pkg::RES_FAIL},
        '{9'd1,   1'b0, 8'h96, 8'h24, 32'h0000_0000, 1'b0, crcbec_pkg::RES_OK},
        // Page size zero is taken as one; pair search on.
        '{9'd0,   1'b1, 8'h11, 8'h00, 32'h8000_0001, 1'b1, crcbec_pkg::RES_TWO},
        '{9'd0,   1'b1, 8'h22, 8'h81, 32'h0000_0000, 1'b0, crcbec_pkg::RES_OK},
        '{9'd0,   1'b1, 8'h33, 8'h10, 32'h0001_0000, 1'b0, crcbec_pkg::RES_OK},
        '{9'd0,   1'b1, 8'hE1, 8'h00, 32'hDEAD_BEEF, 1'b0, crcbec_pkg::RES_OK},
        // Five bytes of a nine-byte page, then the page shrinks under the block's feet:
        // the next byte is already past the new size and closes the page.
        '{9'd9,   1'b0, 8'h01, 8'h00, 32'h0000_0000, 1'b0, crcbec_pkg::RES_OK},
        '{9'd9,   1'b0, 8'h02, 8'h00, 32'h0000_0000, 1'b0, crcbec_pkg::RES_OK},
        '{9'd9,   1'b0, 8'h04, 8'h00, 32'h0000_0000, 1'b0, crcbec_pkg::RES_OK},
        '{9'd9,   1'b0, 8'h08, 8'h00, 32'h0000_0000, 1'b0, crcbec_pkg::RES_OK},
        '{9'd9,   1'b0, 8'h10, 8'h00, 32'h0000_0000, 1'b0, crcbec_pkg::RES_OK},
        '{9'd2,   1'b0, 8'h20, 8'h00, 32'h0000_0000, 1'b1, crcbec_pkg::RES_OK}
    };

    // Random phases. Pair search runs on small pages, and on one 256-byte page kept to clean or one-bit errors.
    localparam int N_PHASES = 6;
    localparam phase_t PHASES [N_PHASES] = '{
        '{9'd12,  1'b0, 8'd25, 7'd30, 2'd1},
        '{9'd0,   1'b1, 8'd80, 7'd0,  2'd0},
        '{9'd3,   1'b1, 8'd40, 7'd50, 2'd2},
        '{9'd256, 1'b0, 8'd2,  7'd20, 2'd3},
        '{9'd511, 1'b1, 8'd1,  7'd10, 2'd1},
        '{9'd1,   1'b0, 8'd30, 7'd40, 2'd2}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = '0;
    logic [31:0] s_page_crc = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic        m_first_valid;
    logic [7:0]  m_first_byte;
    logic [2:0]  m_first_bit;
    logic        m_second_valid;
    logic [7:0]  m_second_byte;
    logic [2:0]  m_second_bit;

    // Hand-written answer riding along with the request that closes a directed page.
    logic                drv_typed = 1'b0;
    crcbec_pkg::result_t drv_want = crcbec_pkg::RES_OK;

    // Register shadow, shared by the stimulus side and the predictor.
    logic [8:0]  cfg_page = 9'd256;
    logic        cfg_two = 1'b0;

    // Predictor state, advanced on accepted requests.
    logic [31:0] acc_crc = crcbec_pkg::CRC_INIT;
    int          acc_count = 0;
    logic [31:0] step_syndrome [MAX_STEPS];
    fix_report_t page_fix_q [$];

    // Stimulus side keeps the CRC of the uncorrupted page to build the stored CRC.
    logic [31:0] gen_crc = crcbec_pkg::CRC_INIT;
    int          gen_count = 0;

    int fail_count = 0;
    int quiet_cycles = 0;
    int gap_pct = 25;
    int stall_mode = 1;
    int burst_left = 0;
    int stall_tick = 0;
    int ready_run = 0;
    logic ready_hold = 1'b1;

    crc32_bit_error_corrector_core #(
        .MAX_PAGE_BYTES(MAX_PAGE)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_page_crc     (s_page_crc),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_first_valid  (m_first_valid),
        .m_first_byte   (m_first_byte),
        .m_first_bit    (m_first_bit),
        .m_second_valid (m_second_valid),
        .m_second_byte  (m_second_byte),
        .m_second_bit   (m_second_bit)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [31:0] crc_shift(input logic [31:0] c);
        return (c >> 1) ^ (c[0] ? crcbec_pkg::CRC_POLY : 32'h0000_0000);
    endfunction

    function automatic logic [31:0] crc_fold_byte(input logic [31:0] c, input logic [7:0] d);
        logic [31:0] r;
        r = c ^ {24'h00_0000, d};
        for (int i = 0; i < 8; i++) begin
            r = crc_shift(r);
        end
        return r;
    endfunction

    // Out-of-range sizes are clamped into 1..MAX_PAGE.
    function automatic int effective_page(input logic [8:0] pg);
        if (pg == 9'd0) begin
            return 1;
        end
        if (int'(pg) > MAX_PAGE) begin
            return MAX_PAGE;
        end
        return int'(pg);
    endfunction

    // Search step i stands for codeword bit bits-1-i; only data bytes are reported.
    function automatic flip_loc_t locate_flip(input int step, input int bits, input int size);
        flip_loc_t l;
        int p;
        l = '0;
        p = bits - 1 - step;
        if (p / 8 < size) begin
            l.valid    = 1'b1;
            l.byte_idx = 8'(p / 8);
            l.bit_idx  = 3'(p % 8);
        end
        return l;
    endfunction

    // Turns a syndrome into the report: single-bit scan first, then every ordered pair
    // when enabled. The first hit in scan order wins.
    function automatic fix_report_t predict_page_fix(input logic [31:0] syn, input int size,
                                                     input logic two);
        fix_report_t r;
        int bits;
        logic [31:0] pat;
        r = '0;
        if (syn == 32'h0) begin
            return r;
        end
        bits = (size + 4) * 8;
        pat = crcbec_pkg::PATTERN_START;
        for (int i = 0; i < bits; i++) begin
            step_syndrome[i] = pat;
            pat = crc_shift(pat);
        end
        for (int i = 0; i < bits; i++) begin
            if (step_syndrome[i] == syn) begin
                r.status = crcbec_pkg::RES_ONE;
                r.first  = locate_flip(i, bits, size);
                return r;
            end
        end
        if (two) begin
            for (int i = 0; i < bits; i++) begin
                for (int j = 0; j < bits; j++) begin
                    if ((step_syndrome[i] ^ step_syndrome[j]) == syn) begin
                        r.status = crcbec_pkg::RES_TWO;
                        r.first  = locate_flip(i, bits, size);
                        r.second = locate_flip(j, bits, size);
                        return r;
                    end
                end
            end
        end
        r.status = crcbec_pkg::RES_FAIL;
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            fail_count++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // Monitor and predictor. Everything is sampled at the rising edge, before the
    // testbench's own nonblocking updates land, so it sees what the block sees.
    always @(posedge aclk) begin : monitor
        fix_report_t want;
        fix_report_t got;
        logic [31:0] syn;
        int size;
        if (m_valid && m_ready) begin
            got.status        = crcbec_pkg::result_t'(m_status);
            got.first.valid   = m_first_valid;
            got.first.byte_idx = m_first_byte;
            got.first.bit_idx = m_first_bit;
            got.second.valid  = m_second_valid;
            got.second.byte_idx = m_second_byte;
            got.second.bit_idx = m_second_bit;
            if (page_fix_q.size() == 0) begin
                fail_count++;
                $display("%0t ns: report with no page outstanding, expected none, %s %0d",
                         $time, "actual status", m_status);
            end else begin
                want = page_fix_q.pop_front();
                check_field("status", want.status, got.status);
                check_field("first_valid", want.first.valid, got.first.valid);
                check_field("first_byte", want.first.byte_idx, got.first.byte_idx);
                check_field("first_bit", want.first.bit_idx, got.first.bit_idx);
                check_field("second_valid", want.second.valid, got.second.valid);
                check_field("second_byte", want.second.byte_idx, got.second.byte_idx);
                check_field("second_bit", want.second.bit_idx, got.second.bit_idx);
            end
        end
        if (s_valid && s_ready) begin
            acc_crc = crc_fold_byte(acc_crc, s_data_byte);
            acc_count++;
            size = effective_page(cfg_page);
            // A byte closes the page once the count reaches or passes the current size.
            if (acc_count >= size) begin
                syn = ~acc_crc ^ s_page_crc;
                acc_crc = crcbec_pkg::CRC_INIT;
                acc_count = 0;
                if (drv_typed) begin
                    want = '0;
                    want.status = drv_want;
                end else begin
                    want = predict_page_fix(syn, size, cfg_two);
                end
                page_fix_q.push_back(want);
            end
        end
    end

    // Result-side back-pressure; the pattern changes per phase.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            case (stall_mode)
                0: begin
                    m_ready <= 1'b1;
                end
                1: begin
                    m_ready <= ($urandom_range(0, 1) == 1);
                end
                2: begin
                    stall_tick = stall_tick + 1;
                    m_ready <= ((stall_tick % 7) < 3);
                end
                default: begin
                    if (ready_run == 0) begin
                        ready_hold = ~ready_hold;
                        ready_run = $urandom_range(1, 30);
                    end else begin
                        ready_run--;
                    end
                    m_ready <= ready_hold;
                end
            endcase
        end
    end

    // Watchdog on progress: any accepted request on either channel resets it.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t ns: watchdog, no request accepted for %0d cycles", $time, quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Register write: setup cycle, then access cycle; then psel drops and the task waits before
    // returning, so that back-to-back writes never reassign psel within one step.
    task automatic write_reg(input logic sel, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (sel == crcbec_pkg::REG_PAGE_BYTES) begin
            cfg_page = val[8:0];
        end else begin
            cfg_two = val[0];
        end
        @(posedge aclk);
    endtask

    // Upper data bits are random; the block must ignore them.
    task automatic configure(input logic [8:0] pg, input logic two);
        write_reg(crcbec_pkg::REG_PAGE_BYTES, ($urandom & ~32'h1FF) | {23'h0, pg});
        write_reg(crcbec_pkg::REG_TWO_BIT, ($urandom & ~32'h1) | {31'h0, two});
    endtask

    // Stops the sender and waits for every outstanding report, then idles for any byte that
    // was still being folded in.
    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (page_fix_q.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    // Sends one page byte. The stored CRC is the clean page's CRC with crc_flip applied
    // when this byte closes the page, and random noise otherwise.
    task automatic push_byte(input logic [7:0] true_b, input logic [7:0] flip,
                             input logic [31:0] crc_flip, input logic has_typed,
                             input crcbec_pkg::result_t typed_status);
        logic [31:0] stored;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            if ($urandom_range(0, 99) < gap_pct) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
        end
        burst_left--;
        gen_crc = crc_fold_byte(gen_crc, true_b);
        gen_count++;
        if (gen_count >= effective_page(cfg_page)) begin
            stored = ~gen_crc ^ crc_flip;
            gen_crc = crcbec_pkg::CRC_INIT;
            gen_count = 0;
        end else begin
            stored = $urandom;
        end
        s_valid      <= 1'b1;
        s_data_byte  <= true_b ^ flip;
        s_page_crc   <= stored;
        drv_typed    <= has_typed;
        drv_want     <= typed_status;
        do @(posedge aclk); while (!s_ready);
    endtask

    // One whole page with random content and an error pattern drawn from: clean, one bit,
    // two bits, or a random stored CRC. Pages over 16 bytes with pair search get clean or one-bit
    // pages only, since a failed pair search there would scan every ordered pair of a long codeword.
    task automatic send_random_page();
        logic [7:0]  flips [MAX_PAGE];
        logic [31:0] crc_flip;
        logic [7:0]  val;
        int size;
        int bits;
        int kind;
        int n_err;
        int pos;
        int fill;
        size = effective_page(cfg_page);
        bits = (size + 4) * 8;
        for (int k = 0; k < MAX_PAGE; k++) begin
            flips[k] = 8'h00;
        end
        crc_flip = 32'h0;
        kind = $urandom_range(0, 99);
        if (cfg_two && size > 16 && kind >= 60) begin
            kind = $urandom_range(0, 59);
        end
        fill = $urandom_range(0, 9);
        if (kind >= 85) begin
            crc_flip = $urandom;
        end else begin
            n_err = (kind < 30) ? 0 : (kind < 60) ? 1 : 2;
            for (int e = 0; e < n_err; e++) begin
                pos = $urandom_range(0, bits - 1);
                if (pos < size * 8) begin
                    flips[pos / 8][pos % 8] = ~flips[pos / 8][pos % 8];
                end else begin
                    crc_flip[pos - size * 8] = ~crc_flip[pos - size * 8];
                end
            end
        end
        for (int k = 0; k < size; k++) begin
            val = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom);
            push_byte(val, flips[k], crc_flip, 1'b0, crcbec_pkg::RES_OK);
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (3) @(posedge aclk);

        // Directed rows; the registers change only with nothing in flight.
        for (int r = 0; r < N_DIRECTED; r++) begin
            if (DIRECTED[r].pg != cfg_page || DIRECTED[r].two != cfg_two) begin
                wait_idle();
                configure(DIRECTED[r].pg, DIRECTED[r].two);
            end
            push_byte(DIRECTED[r].data, DIRECTED[r].flip, DIRECTED[r].crc_flip,
                      DIRECTED[r].typed, DIRECTED[r].want);
        end

        // Random pages, phase by phase.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_idle();
            configure(PHASES[ph].pg, PHASES[ph].two);
            gap_pct = PHASES[ph].gap_pct;
            stall_mode = PHASES[ph].stall;
            for (int n = 0; n < PHASES[ph].pages; n++) begin
                send_random_page();
            end
        end

        wait_idle();
        repeat (56) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/crcbec_pkg.sv
rtl/crcbec_ctrl.sv
rtl/crcbec_datapath.sv
rtl/crc32_bit_error_corrector_core.sv
verif/testbench.sv
